// ----- rtl/core/dq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Holds the command and status codes, the beat structs and the control struct.
// No dependencies.
package dq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int WORD_W        = 32;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_BACK   = 2'd2,
        CMD_POP_FRONT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic [1:0]               status;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;   // take the command beat this cycle
        logic respond;  // present the result beat this cycle
    } t_dq_ctl;

endpackage

// ----- rtl/core/dq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dq_ctrl.sv -----
// Controller for the double-ended queue: two-state sequencer for accept and reply.
// Depends on dq_pkg.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dq_ctl o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state == S_RESP);
    assign o_ctl.accept  = start && (r_state == S_IDLE);
    assign o_ctl.respond = (r_state == S_RESP);

endmodule

// ----- rtl/core/dq_datapath.sv -----
// Datapath for the double-ended queue: head and count registers, ring RAM, result.
// Depends on dq_pkg and dq_ram.
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dq_ctl   i_ctl,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 1;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [AW-1:0]     r_head;
    logic [AW-1:0]     n_head;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    t_status           r_status;
    t_status           n_status;
    logic              r_pop_ok;
    logic              n_pop_ok;

    logic              full;
    logic              empty;
    logic [PW-1:0]     back_sum;
    logic [PW-1:0]     tail_sum;
    logic [AW-1:0]     back_pos;
    logic [AW-1:0]     tail_pos;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign full  = (r_count == FULL_C);
    assign empty = (r_count == '0);

    // Ring positions: the sums stay below twice the depth, so one subtract wraps them.
    assign back_sum = PW'(r_head) + PW'(r_count);
    assign tail_sum = back_sum - PW'(1);
    assign back_pos = (back_sum >= DEPTH_P) ? AW'(back_sum - DEPTH_P) : AW'(back_sum);
    assign tail_pos = (tail_sum >= DEPTH_P) ? AW'(tail_sum - DEPTH_P) : AW'(tail_sum);
    assign head_dec = (r_head == '0) ? LAST_A : r_head - AW'(1);
    assign head_inc = (r_head == LAST_A) ? '0 : r_head + AW'(1);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_status  = ST_OK;
        n_pop_ok  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = back_pos;
        ram_raddr = r_head;
        case (t_cmd'(i_item.command))
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we  = i_ctl.accept;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we    = i_ctl.accept;
                    ram_waddr = head_dec;
                    n_head    = head_dec;
                    n_count   = r_count + CW'(1);
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_raddr = tail_pos;
                    n_pop_ok  = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head   = head_inc;
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.push_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Count and head already hold the post-command values while the reply is up.
    assign o_result.popped_value = r_pop_ok ? ram_rdata : '0;
    assign o_result.status       = r_status;
    assign o_result.is_empty     = empty;
    assign o_result.occupancy    = OCC_W'(r_count);

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// Top level of the double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_ctrl and dq_datapath (which holds dq_ram).
//
//  Channel   | Ports                    | Beat taken when
//  ----------+--------------------------+------------------------------
//  command   | start, busy, i_item      | rising edge with start=1, busy=0
//  result    | o_valid, o_result        | rising edge ending the o_valid cycle
//
// Sequence: in the accept cycle the head and count are updated and the ring
// RAM is written (push) or read (pop); in the next cycle busy is high and the
// result beat is shown from the RAM's registered read port. A new command may
// be accepted in the cycle after that.
// Reset: synchronous, active low; clears the sequencer, head and count. RAM
// contents are not cleared, since an entry is read only after it was pushed.
// Stalls: the receiver cannot hold results off; o_valid lasts exactly one cycle.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    t_dq_ctl ctl;

    // Sequencer: accept a command, then present its result beat.
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    // Index arithmetic, ring store and result formatting.
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_item),
        .o_result (o_result)
    );

    assign o_valid = ctl.respond;

    // Every accepted command yields its result beat in the very next cycle.
    a_reply_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy) |=> o_valid)
        else $error("result beat missing after accepted command");

    // A rejected push only happens with the queue full.
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_FULL) |->
        (o_result.occupancy == FULL_OCC && !o_result.is_empty))
        else $error("full status with queue not full");

    // A rejected pop leaves an empty queue and returns zero.
    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_EMPTY) |->
        (o_result.is_empty && o_result.popped_value == '0))
        else $error("empty status with entries held or nonzero word");

    // No new command is taken while a result beat is up.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !ctl.accept)
        else $error("command accepted during result beat");

endmodule

// ----- tb/dq_shadow_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard class for the double-ended queue testbench: a shadow ring that
// predicts every result beat and checks the beats the block returns. Needs dq_pkg.
package dq_shadow_pkg;
    import dq_pkg::*;

    localparam int RING_DEPTH = DEFAULT_DEPTH;

    class deque_shadow;
        logic signed [WORD_W-1:0] ring [RING_DEPTH];
        int                       head;
        int                       count;
        t_out_item                pending_results [$];
        int unsigned              mismatches;

        function new();
            head       = 0;
            count      = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted command beat to the shadow ring and queue its result.
        function void note_command(t_in_item item);
            t_out_item res;
            int        slot;
            res        = '0;
            res.status = ST_OK;
            case (t_cmd'(item.command))
                CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                    if (count == RING_DEPTH) begin
                        res.status = ST_FULL;
                    end else if (t_cmd'(item.command) == CMD_PUSH_BACK) begin
                        slot       = (head + count) % RING_DEPTH;
                        ring[slot] = item.push_value;
                        count++;
                    end else begin
                        head       = (head + RING_DEPTH - 1) % RING_DEPTH;
                        ring[head] = item.push_value;
                        count++;
                    end
                end
                default: begin
                    if (count == 0) begin
                        res.status = ST_EMPTY;
                    end else if (t_cmd'(item.command) == CMD_POP_BACK) begin
                        slot             = (head + count - 1) % RING_DEPTH;
                        res.popped_value = ring[slot];
                        count--;
                    end else begin
                        res.popped_value = ring[head];
                        head             = (head + 1) % RING_DEPTH;
                        count--;
                    end
                end
            endcase
            res.is_empty  = (count == 0);
            res.occupancy = count[OCC_W-1:0];
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void compare_field(string field, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %0h", got);
                mismatches++;
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            compare_field("popped_value", want.popped_value, got.popped_value);
            compare_field("status", want.status, got.status);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

endpackage

// ----- tb/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps
// Top-level testbench for double_ended_queue: directed corner cases, then random
// push/pop bursts, checked beat by beat. Needs dq_pkg and dq_shadow_pkg.
module tb_double_ended_queue;
    import dq_pkg::*;
    import dq_shadow_pkg::*;

    // 1900-odd commands with long gaps stay far below this bound, so reaching
    // it means the block has hung.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BEATS = 1900;
    localparam int SETTLE       = 8;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    deque_shadow shadow;
    int unsigned cycle_count = 0;

    double_ended_queue #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: drop the run if the block stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result beats last one cycle and cannot be held off. All DUT outputs move
    // only at rising edges, so sample them mid-cycle on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            shadow.check_result(o_result);
        end
    end

    // Present one command beat and hold it until the block takes it. Call right
    // after a rising edge; returns right after the edge that accepted the beat,
    // with start still high so the next beat can follow back to back.
    task automatic send_command(input t_cmd cmd, input logic signed [WORD_W-1:0] value);
        t_in_item beat;
        logic     taken;
        beat.command    = cmd;
        beat.push_value = value;
        start  <= 1'b1;
        i_item <= beat;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        shadow.note_command(beat);
    endtask

    // Lower start for a while; zero cycles means the next beat follows at once.
    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 9);
        return $urandom_range(10, 40);
    endfunction

    // Extremes and small values often enough to show up in pops; full-range
    // random words toggle every bit.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shffff_ffff;
            4:       return $signed($urandom_range(0, 15)) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        int   issued;
        int   burst_len;
        int   push_pct;
        logic no_gaps;
        logic is_push;

        shadow = new();

        // Hold reset low first, then release it for good.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pops from an empty queue must be refused with the state untouched.
        send_command(CMD_POP_BACK, 32'sh1234_5678);
        send_command(CMD_POP_FRONT, 32'shffff_ffff);

        // Word extremes through both ends; the head wraps below zero at once.
        send_command(CMD_PUSH_BACK, 32'sh7fff_ffff);
        send_command(CMD_PUSH_FRONT, 32'sh8000_0000);
        idle_for(3);
        send_command(CMD_POP_BACK, 32'sh0);
        send_command(CMD_POP_FRONT, 32'sh0);

        // Fill to the brim from both ends, then push into a full queue.
        for (int i = 0; i < RING_DEPTH; i++) begin
            send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $signed($urandom()));
        end
        send_command(CMD_PUSH_BACK, 32'sh5555_5555);
        send_command(CMD_PUSH_FRONT, 32'shaaaa_aaaa);

        // Random bursts, each with its own push bias so the occupancy sweeps
        // between empty and full and both refusals keep recurring. Some bursts
        // run with start held high throughout.
        issued = 0;
        while (issued < RANDOM_BEATS) begin
            burst_len = $urandom_range(8, 60);
            case ($urandom_range(0, 4))
                0:       push_pct = 90;
                1:       push_pct = 10;
                2:       push_pct = 70;
                3:       push_pct = 30;
                default: push_pct = 50;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < burst_len && issued < RANDOM_BEATS; n++) begin
                is_push = ($urandom_range(0, 99) < push_pct);
                if (is_push) begin
                    send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                 pick_word());
                end else begin
                    send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                                 $signed($urandom()));
                end
                issued++;
                if (!no_gaps) begin
                    idle_for(pick_gap());
                end
            end
        end
        start <= 1'b0;

        // Drain: wait for every expected beat, then watch for strays.
        while (shadow.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);

        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
